/* sv/mcwpr_pkg.sv */
// ----------------------------------------------------------------------------
// mcwpr_pkg
// shared types and constants of the multichannel window peak and rms meter
// ----------------------------------------------------------------------------
`default_nettype none

package mcwpr_pkg;

	// parameter defaults
	localparam int CHANNELS_DEF    = 8;
	localparam int MAX_WINDOW_DEF  = 4096;
	localparam int SAMPLE_BITS_DEF = 24;

	// fixed field widths
	localparam int ACTION_W  = 2;
	localparam int CHANNEL_W = 3;
	localparam int FILL_W    = 13;
	localparam int CFG_W     = 13;

	// command queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;

	typedef enum logic [ACTION_W-1:0] {
		ACT_APPEND = 2'd0,
		ACT_QUERY  = 2'd1,
		ACT_CLEAR  = 2'd2
	} action_t;

	// one queued command, sample travels beside it
	typedef struct packed {
		action_t              act;
		logic [CHANNEL_W-1:0] ch;
		logic                 off_range;
	} cmd_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_WALK,
		B_DRAIN,
		B_CALC,
		B_FIN
	} bstate_t;

	typedef enum logic [1:0] {
		U_IDLE,
		U_DIV,
		U_SQRT
	} ustate_t;

endpackage

`default_nettype wire

/* sv/mcwpr_front.sv */
// ----------------------------------------------------------------------------
// mcwpr_front
// accepts words, drops those without effect, queues commands for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module mcwpr_front #(
	parameter int CHANNELS    = mcwpr_pkg::CHANNELS_DEF,
	parameter int SAMPLE_BITS = mcwpr_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [mcwpr_pkg::ACTION_W-1:0] action,
	input  wire logic [mcwpr_pkg::CHANNEL_W-1:0] channel,
	input  wire logic signed [SAMPLE_BITS-1:0]  sample,
	output logic                                cmd_valid,
	output mcwpr_pkg::cmd_t                     cmd,
	output logic [SAMPLE_BITS-1:0]              cmd_sample,
	input  wire logic                           cmd_pop
);
	import mcwpr_pkg::*;

	cmd_t                   cmd_mem_q [QDEPTH];
	logic [SAMPLE_BITS-1:0] smp_mem_q [QDEPTH];
	logic [QPTR_W-1:0]      wptr_q, rptr_q;
	logic [QPTR_W:0]        cnt_q;
	logic                   in_range, keep, push;
	cmd_t                   new_cmd;

	assign in_range = 32'(channel) < CHANNELS;

	// classify: unused action and out-of-range appends leave no trace
	always_comb begin
		keep = 1'b0;
		unique case (action_t'(action))
			ACT_APPEND: keep = in_range;
			ACT_QUERY:  keep = 1'b1;
			ACT_CLEAR:  keep = 1'b1;
			default:    keep = 1'b0;
		endcase
	end

	assign new_cmd.act       = action_t'(action);
	assign new_cmd.ch        = channel;
	assign new_cmd.off_range = !in_range;

	assign in_ready   = cnt_q != (QPTR_W+1)'(QDEPTH);
	assign push       = in_valid && in_ready && keep;
	assign cmd_valid  = cnt_q != '0;
	assign cmd        = cmd_mem_q[rptr_q];
	assign cmd_sample = smp_mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push)
				wptr_q <= wptr_q + 1'b1;
			if (cmd_pop)
				rptr_q <= rptr_q + 1'b1;
			if (push && !cmd_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (!push && cmd_pop)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			cmd_mem_q[wptr_q] <= new_cmd;
			smp_mem_q[wptr_q] <= sample;
		end
	end

endmodule

`default_nettype wire

/* sv/mcwpr_msqrt.sv */
// ----------------------------------------------------------------------------
// mcwpr_msqrt
// bit-serial mean (sum / count) followed by bit-serial floor square root
// ----------------------------------------------------------------------------
`default_nettype none

module mcwpr_msqrt #(
	parameter int SUM_W = 61,
	parameter int WL_W  = 13,
	parameter int SB    = 24
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [SUM_W-1:0] sum,
	input  wire logic [WL_W-1:0]  n,
	output logic                  done,
	output logic [SB-1:0]         root
);
	import mcwpr_pkg::*;

	localparam int CW = $clog2(SUM_W + 1);

	ustate_t             st_q, st_d;
	logic [CW-1:0]       cnt_q, cnt_d;
	logic                done_q, done_d;
	logic [SUM_W-1:0]    quo_q, quo_nx;
	logic [WL_W-1:0]     rem_q;
	logic [WL_W:0]       trial, diff;
	logic                ge;
	logic [2*SB-1:0]     rad_q;
	logic [SB+1:0]       srem_q;
	logic [SB-1:0]       root_q;
	logic [SB+3:0]       stmp, strial, sdiff;
	logic                sge;

	// restoring divide step
	assign trial  = {rem_q, quo_q[SUM_W-1]};
	assign ge     = trial >= {1'b0, n};
	assign diff   = trial - {1'b0, n};
	assign quo_nx = {quo_q[SUM_W-2:0], ge};

	// square root step, two radicand bits in
	assign stmp   = {srem_q, rad_q[2*SB-1 -: 2]};
	assign strial = {2'b00, root_q, 2'b01};
	assign sge    = stmp >= strial;
	assign sdiff  = stmp - strial;

	always_comb begin
		st_d   = st_q;
		cnt_d  = cnt_q;
		done_d = 1'b0;
		unique case (st_q)
			U_IDLE: if (start) begin
				st_d  = U_DIV;
				cnt_d = CW'(SUM_W);
			end
			U_DIV: begin
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					st_d  = U_SQRT;
					cnt_d = CW'(SB);
				end
			end
			U_SQRT: begin
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					st_d   = U_IDLE;
					done_d = 1'b1;
				end
			end
			default: st_d = U_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= U_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			cnt_q  <= cnt_d;
			done_q <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == U_IDLE && start) begin
			quo_q <= sum;
			rem_q <= '0;
		end else if (st_q == U_DIV) begin
			quo_q <= quo_nx;
			rem_q <= ge ? diff[WL_W-1:0] : trial[WL_W-1:0];
			if (cnt_q == CW'(1)) begin
				rad_q  <= quo_nx[2*SB-1:0];
				srem_q <= '0;
				root_q <= '0;
			end
		end else if (st_q == U_SQRT) begin
			rad_q  <= {rad_q[2*SB-3:0], 2'b00};
			srem_q <= sge ? sdiff[SB+1:0] : stmp[SB+1:0];
			root_q <= {root_q[SB-2:0], sge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

/* sv/mcwpr_back.sv */
// ----------------------------------------------------------------------------
// mcwpr_back
// sample store, per-channel window pointers, window walk and result register
// ----------------------------------------------------------------------------
`default_nettype none

module mcwpr_back #(
	parameter int CHANNELS    = mcwpr_pkg::CHANNELS_DEF,
	parameter int MAX_WINDOW  = mcwpr_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = mcwpr_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cmd_valid,
	input  wire mcwpr_pkg::cmd_t              cmd,
	input  wire logic [SAMPLE_BITS-1:0]       cmd_sample,
	output logic                              cmd_pop,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [mcwpr_pkg::CFG_W-1:0]  cfg_data,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [SAMPLE_BITS-1:0]            peak,
	output logic [SAMPLE_BITS-1:0]            rms,
	output logic [mcwpr_pkg::FILL_W-1:0]      fill
);
	import mcwpr_pkg::*;

	localparam int SB    = SAMPLE_BITS;
	localparam int WL_W  = $clog2(MAX_WINDOW + 1);
	localparam int PW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CIW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int DEPTH = CHANNELS * MAX_WINDOW;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SUM_W = 2 * SB + WL_W;

	bstate_t          st_q, st_d;
	logic [WL_W-1:0]  wlen_q, wlen_d;
	logic [WL_W-1:0]  held_q   [CHANNELS];
	logic [PW-1:0]    oldest_q [CHANNELS];

	logic             cmd_pop_c, do_append, do_clear, take_query, issue, start, load_out;
	logic [CIW-1:0]   hch;
	logic [WL_W-1:0]  hheld;
	logic [PW-1:0]    hold, wpos, onx;
	logic [WL_W:0]    psum, pwrap;
	logic             full;
	logic [31:0]      cfg_ext;

	logic [SB-1:0]    mem [DEPTH];
	logic [AW-1:0]    waddr, raddr;

	logic [CIW-1:0]   qch_q;
	logic [WL_W-1:0]  n_q, widx_q;
	logic [PW-1:0]    wptr_q;
	logic             zero_q;
	logic             rd_v_s1, v_s2;
	logic [SB-1:0]    rdata_s1, mag_s1, mag_s2;
	logic [2*SB-1:0]  sq_s2;
	logic [SB-1:0]    peak_q;
	logic [SUM_W-1:0] sum_q;
	logic             out_valid_q;
	logic [SB-1:0]    peak_o_q, rms_o_q;
	logic [FILL_W-1:0] fill_o_q;
	logic             u_done;
	logic [SB-1:0]    u_root;

	// window length register: zero taken as one, clipped to MAX_WINDOW
	assign cfg_ready = 1'b1;
	assign cfg_ext   = 32'(cfg_data);
	assign wlen_d    = (cfg_ext == 32'd0)       ? WL_W'(1) :
	                   (cfg_ext > MAX_WINDOW)   ? WL_W'(MAX_WINDOW) : WL_W'(cfg_ext);

	// head of queue, append position
	assign hch   = CIW'(cmd.ch);
	assign hheld = held_q[hch];
	assign hold  = oldest_q[hch];
	assign full  = hheld >= wlen_q;
	assign psum  = (WL_W+1)'(hold) + (WL_W+1)'(hheld);
	assign pwrap = (psum >= (WL_W+1)'(wlen_q)) ? psum - (WL_W+1)'(wlen_q) : psum;
	assign wpos  = full ? hold : PW'(pwrap);
	assign onx   = ((WL_W'(hold) + 1'b1) == wlen_q) ? '0 : hold + 1'b1;

	assign waddr = AW'(hch) * AW'(MAX_WINDOW) + AW'(wpos);
	assign raddr = AW'(qch_q) * AW'(MAX_WINDOW) + AW'(wptr_q);

	always_comb begin
		st_d       = st_q;
		cmd_pop_c  = 1'b0;
		do_append  = 1'b0;
		do_clear   = 1'b0;
		take_query = 1'b0;
		issue      = 1'b0;
		start      = 1'b0;
		load_out   = 1'b0;
		unique case (st_q)
			B_IDLE: if (cmd_valid) begin
				cmd_pop_c = 1'b1;
				unique case (cmd.act)
					ACT_APPEND: do_append = 1'b1;
					ACT_CLEAR:  do_clear  = 1'b1;
					ACT_QUERY: begin
						take_query = 1'b1;
						st_d = (cmd.off_range || hheld == '0) ? B_FIN : B_WALK;
					end
					default: ;
				endcase
			end
			B_WALK: begin
				issue = 1'b1;
				if (widx_q == n_q - 1'b1)
					st_d = B_DRAIN;
			end
			B_DRAIN: if (!rd_v_s1 && !v_s2) begin
				start = 1'b1;
				st_d  = B_CALC;
			end
			B_CALC: if (u_done)
				st_d = B_FIN;
			B_FIN: if (!out_valid_q || out_ready) begin
				load_out = 1'b1;
				st_d     = B_IDLE;
			end
			default: st_d = B_IDLE;
		endcase
	end

	assign cmd_pop = cmd_pop_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= B_IDLE;
			wlen_q      <= WL_W'(MAX_WINDOW);
			out_valid_q <= 1'b0;
			rd_v_s1     <= 1'b0;
			v_s2        <= 1'b0;
			for (int c = 0; c < CHANNELS; c++) begin
				held_q[c]   <= '0;
				oldest_q[c] <= '0;
			end
		end else begin
			st_q    <= st_d;
			rd_v_s1 <= issue;
			v_s2    <= rd_v_s1;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (cfg_valid || do_clear) begin
				if (cfg_valid)
					wlen_q <= wlen_d;
				for (int c = 0; c < CHANNELS; c++) begin
					held_q[c]   <= '0;
					oldest_q[c] <= '0;
				end
			end else if (do_append) begin
				if (full)
					oldest_q[hch] <= onx;
				else
					held_q[hch] <= hheld + 1'b1;
			end
		end
	end

	// sample store
	always_ff @(posedge clk) begin
		if (do_append)
			mem[waddr] <= cmd_sample;
		rdata_s1 <= mem[raddr];
	end

	assign mag_s1 = rdata_s1[SB-1] ? (~rdata_s1 + 1'b1) : rdata_s1;

	// walk pointers, square stage, accumulators, result register
	always_ff @(posedge clk) begin
		if (take_query) begin
			qch_q  <= hch;
			n_q    <= hheld;
			wptr_q <= hold;
			widx_q <= '0;
			zero_q <= cmd.off_range || hheld == '0;
			peak_q <= '0;
			sum_q  <= '0;
		end else begin
			if (issue) begin
				wptr_q <= ((WL_W'(wptr_q) + 1'b1) == wlen_q) ? '0 : wptr_q + 1'b1;
				widx_q <= widx_q + 1'b1;
			end
			if (v_s2) begin
				if (mag_s2 > peak_q)
					peak_q <= mag_s2;
				sum_q <= sum_q + SUM_W'(sq_s2);
			end
		end
		mag_s2 <= mag_s1;
		sq_s2  <= mag_s1 * mag_s1;
		if (load_out) begin
			peak_o_q <= zero_q ? '0 : peak_q;
			rms_o_q  <= zero_q ? '0 : u_root;
			fill_o_q <= zero_q ? '0 : FILL_W'(n_q);
		end
	end

	mcwpr_msqrt #(
		.SUM_W (SUM_W),
		.WL_W  (WL_W),
		.SB    (SB)
	) u_msqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sum    (sum_q),
		.n      (n_q),
		.done   (u_done),
		.root   (u_root)
	);

	assign out_valid = out_valid_q;
	assign peak      = peak_o_q;
	assign rms       = rms_o_q;
	assign fill      = fill_o_q;

endmodule

`default_nettype wire

/* sv/multichannel_window_peak_rms.sv */
// ----------------------------------------------------------------------------
// multichannel_window_peak_rms
// per-channel circular sample windows with peak and rms query
// ----------------------------------------------------------------------------
//
//  channel  signals                      word carries
//  -------  ---------------------------  -------------------------------------
//  in       in_valid / in_ready          action, channel, sample
//  out      out_valid / out_ready        peak_magnitude, rms_level, fill_count
//  cfg      cfg_valid / cfg_ready        window_length
//
//  appends and clears are each done by the back end as it pops them, so a
//  stream of appends runs at one word a cycle through the four-entry command
//  queue while no query holds the back end; a query holds it for n store
//  reads (n the window fill), then a bit-serial divider and root
//  in_ready only drops when the command queue is full; a held result in
//  the output register stalls the back end only at the next query's end
//  reset clears the queue, the window pointers and counts, and sets the
//  window length to MAX_WINDOW; the sample store itself is never cleared
//
`default_nettype none

module multichannel_window_peak_rms #(
	parameter int CHANNELS    = mcwpr_pkg::CHANNELS_DEF,
	parameter int MAX_WINDOW  = mcwpr_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = mcwpr_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// input words
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [mcwpr_pkg::ACTION_W-1:0]  action,
	input  wire logic [mcwpr_pkg::CHANNEL_W-1:0] channel,
	input  wire logic signed [SAMPLE_BITS-1:0]   sample,
	// result words
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [SAMPLE_BITS-1:0]               peak_magnitude,
	output logic [SAMPLE_BITS-1:0]               rms_level,
	output logic [mcwpr_pkg::FILL_W-1:0]         fill_count,
	// window length register
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [mcwpr_pkg::CFG_W-1:0]     window_length
);
	import mcwpr_pkg::*;

	logic                   cmd_valid, cmd_pop;
	cmd_t                   cmd;
	logic [SAMPLE_BITS-1:0] cmd_sample;

	// front end: classify and queue
	mcwpr_front #(
		.CHANNELS    (CHANNELS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.channel    (channel),
		.sample     (sample),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_sample (cmd_sample),
		.cmd_pop    (cmd_pop)
	);

	// back end: store, walk, statistics
	mcwpr_back #(
		.CHANNELS    (CHANNELS),
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_sample (cmd_sample),
		.cmd_pop    (cmd_pop),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (window_length),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.peak       (peak_magnitude),
		.rms        (rms_level),
		.fill       (fill_count)
	);

	// an empty window reports all zeros
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fill_count == '0 |-> peak_magnitude == '0 && rms_level == '0)
		else $error("empty window gave non-zero statistics");

	// rms of a window never exceeds its peak
	a_rms_le_peak: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> rms_level <= peak_magnitude)
		else $error("rms above peak");

	// a pop always frees room: the queue is never full after a pop
	a_pop_frees: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> in_ready)
		else $error("queue still full after a pop");

endmodule

`default_nettype wire
